@@ rtl/core/xpid_pkg.sv @@
// Package for the inbound deframer: packet kinds, header constants and the
// per-packet summary record passed between pipeline stages.
// No dependencies.
`default_nettype none

package xpid_pkg;

    localparam logic [1:0] KIND_ERROR = 2'd0;
    localparam logic [1:0] KIND_REPLY = 2'd1;
    localparam logic [1:0] KIND_EVENT = 2'd2;

    localparam logic [7:0] TYPE_ERROR  = 8'd0;
    localparam logic [7:0] TYPE_REPLY  = 8'd1;
    localparam logic [7:0] EXPOSE_CODE = 8'd12;

    localparam int unsigned HEADER_WORDS = 8;
    localparam logic [2:0]  POS_START    = 3'd0;
    localparam logic [2:0]  POS_VALUE    = 3'd1;
    localparam logic [2:0]  POS_OPCODES  = 3'd2;
    localparam logic [2:0]  POS_SIZE     = 3'd3;
    localparam logic [2:0]  POS_LAST     = 3'(HEADER_WORDS - 1);

    localparam logic [15:0] SEQ_WINDOW = 16'h8000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] seq;
        logic [7:0]  code;
        logic [7:0]  major;
        logic [15:0] minor;
        logic [31:0] value;
        logic        expose;
        logic [15:0] area_w;
        logic [15:0] area_h;
        logic [31:0] payload;
    } xpid_sum_t;

endpackage

`default_nettype wire

@@ rtl/core/x_protocol_inbound_deframer_top.sv @@
// Top level of the inbound deframer: framer followed by the context slot
// pipeline. Depends on xpid_pkg, xpid_frm and xpid_slot.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one inbound 32-bit word per item
//   with the current request count. Output channel (out_valid/out_ready)
//   carries one packet summary per finished packet: errors and events at
//   header word 8, replies at their last payload word (or header word 8 when
//   reply length is zero). Other words give no result.
//   Path: from the edge that accepts the packet's last word, a summary passes
//   the framer register, reciprocal multiply, back multiply and correction
//   into the output register, where it appears on out_valid.
//   Throughput: one word per cycle while in_ready is high; every stage advances
//   independently, so bubbles are filled and words keep entering while a summary waits.
//   Receiver stall: out_valid and fields hold; stages fill up, then in_ready
//   drops once the framer register is full and cannot move.
//   Reset: asynchronous active low; framer expects a packet start, all
//   payload counters and stage valid bits clear.
`default_nettype none

module x_protocol_inbound_deframer_top #(
    parameter int unsigned CONTEXT_SLOTS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] stream_word,
    input  logic [31:0] request_count,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  packet_kind,
    output logic [31:0] full_sequence,
    output logic [7:0]  context_slot,
    output logic [7:0]  detail_code,
    output logic [7:0]  failed_major,
    output logic [15:0] failed_minor,
    output logic [31:0] value_or_window,
    output logic        is_expose,
    output logic [15:0] area_width,
    output logic [15:0] area_height,
    output logic [31:0] payload_words
);
    import xpid_pkg::*;

    logic      sum_valid;
    logic      sum_ready;
    xpid_sum_t sum;
    xpid_sum_t out_rec;

    xpid_frm u_frm (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .stream_word   (stream_word),
        .request_count (request_count),
        .sum_valid     (sum_valid),
        .sum_ready     (sum_ready),
        .sum           (sum)
    );

    xpid_slot #(
        .CONTEXT_SLOTS (CONTEXT_SLOTS)
    ) u_slot (
        .clk       (clk),
        .rst_n     (rst_n),
        .sum_valid (sum_valid),
        .sum_ready (sum_ready),
        .sum       (sum),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_rec   (out_rec),
        .out_slot  (context_slot)
    );

    assign packet_kind     = out_rec.kind;
    assign full_sequence   = out_rec.seq;
    assign detail_code     = out_rec.code;
    assign failed_major    = out_rec.major;
    assign failed_minor    = out_rec.minor;
    assign value_or_window = out_rec.value;
    assign is_expose       = out_rec.expose;
    assign area_width      = out_rec.area_w;
    assign area_height     = out_rec.area_h;
    assign payload_words   = out_rec.payload;

    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("in_ready low with empty output register");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (packet_kind == KIND_ERROR || packet_kind == KIND_REPLY ||
                       packet_kind == KIND_EVENT))
        else $error("illegal packet kind on output");

    a_event_no_seq: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && packet_kind == KIND_EVENT |-> full_sequence == 32'd0 &&
                                                   context_slot == 8'd0)
        else $error("event carries a sequence or slot");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 32'(context_slot) < 32'(CONTEXT_SLOTS))
        else $error("context slot out of range");

endmodule

`default_nettype wire

@@ rtl/core/xpid_frm.sv @@
// Packet framer: header position counter, reply payload counter, held header
// fields and sequence unwrap; registers one summary per finished packet.
// Depends on xpid_pkg.
`default_nettype none

module xpid_frm (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [31:0]       stream_word,
    input  logic [31:0]       request_count,
    output logic              sum_valid,
    input  logic              sum_ready,
    output xpid_pkg::xpid_sum_t sum
);
    import xpid_pkg::*;

    logic [2:0]  pos_reg,  pos_next;
    logic [31:0] rem_reg,  rem_next;
    logic [1:0]  kind_reg, kind_next;
    logic [15:0] seq_reg,  seq_next;
    logic [7:0]  code_reg, code_next;
    logic [23:0] opc_reg,  opc_next;
    logic [31:0] val_reg,  val_next;
    logic [31:0] size_reg, size_next;
    logic [31:0] len_reg,  len_next;
    logic        s1_v_reg;
    xpid_sum_t   s1_rec_reg;
    xpid_sum_t   rec;
    logic        accept;
    logic        emit;
    logic [7:0]  type_b;

    function automatic logic [31:0] unwrap(input logic [31:0] ref_cnt,
                                           input logic [15:0] wseq);
        logic [15:0] lo;
        logic [15:0] hi;
        lo = ref_cnt[15:0];
        hi = ref_cnt[31:16];
        if (wseq < lo)
        begin
            if ((lo - wseq) > SEQ_WINDOW)
            begin
                hi = hi + 16'd1;
            end
        end
        else if ((wseq - lo) > SEQ_WINDOW)
        begin
            hi = hi - 16'd1;
        end
        return {hi, wseq};
    endfunction

    assign in_ready  = !s1_v_reg || sum_ready;
    assign accept    = in_valid && in_ready;
    assign type_b    = stream_word[7:0];
    assign sum_valid = s1_v_reg;
    assign sum       = s1_rec_reg;

    always_comb
    begin
        pos_next  = pos_reg;
        rem_next  = rem_reg;
        kind_next = kind_reg;
        seq_next  = seq_reg;
        code_next = code_reg;
        opc_next  = opc_reg;
        val_next  = val_reg;
        size_next = size_reg;
        len_next  = len_reg;
        emit      = 1'b0;
        if (rem_reg != 32'd0)
        begin
            rem_next = rem_reg - 32'd1;
            emit     = (rem_reg == 32'd1);
        end
        else
        begin
            case (pos_reg)
                POS_START:
                begin
                    if (type_b == TYPE_ERROR)
                    begin
                        kind_next = KIND_ERROR;
                        code_next = stream_word[15:8];
                    end
                    else if (type_b == TYPE_REPLY)
                    begin
                        kind_next = KIND_REPLY;
                        code_next = 8'd0;
                    end
                    else
                    begin
                        kind_next = KIND_EVENT;
                        code_next = {1'b0, type_b[6:0]};
                    end
                    seq_next  = stream_word[31:16];
                    opc_next  = 24'd0;
                    val_next  = 32'd0;
                    size_next = 32'd0;
                    len_next  = 32'd0;
                end
                POS_VALUE:
                begin
                    if (kind_reg == KIND_REPLY)
                        len_next = stream_word;
                    else
                        val_next = stream_word;
                end
                POS_OPCODES:
                begin
                    if (kind_reg == KIND_ERROR)
                        opc_next = stream_word[23:0];
                end
                POS_SIZE:
                begin
                    if (kind_reg == KIND_EVENT)
                        size_next = stream_word;
                end
                default:
                begin
                end
            endcase
            if (pos_reg == POS_LAST)
            begin
                pos_next = POS_START;
                if (kind_reg == KIND_REPLY && len_reg != 32'd0)
                    rem_next = len_reg;
                else
                    emit = 1'b1;
            end
            else
            begin
                pos_next = pos_reg + 3'd1;
            end
        end
    end

    // summary from held fields; the completing word never changes them
    always_comb
    begin
        rec      = '0;
        rec.kind = kind_reg;
        if (kind_reg == KIND_EVENT)
        begin
            rec.code = code_reg;
            if (code_reg == EXPOSE_CODE)
            begin
                rec.expose = 1'b1;
                rec.value  = val_reg;
                rec.area_w = size_reg[15:0];
                rec.area_h = size_reg[31:16];
            end
        end
        else
        begin
            rec.seq = unwrap(request_count, seq_reg);
            if (kind_reg == KIND_ERROR)
            begin
                rec.code  = code_reg;
                rec.minor = opc_reg[15:0];
                rec.major = opc_reg[23:16];
                rec.value = val_reg;
            end
            else
            begin
                rec.payload = len_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= POS_START;
            rem_reg  <= 32'd0;
            kind_reg <= KIND_ERROR;
            seq_reg  <= 16'd0;
            code_reg <= 8'd0;
            opc_reg  <= 24'd0;
            val_reg  <= 32'd0;
            size_reg <= 32'd0;
            len_reg  <= 32'd0;
            s1_v_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                pos_reg  <= pos_next;
                rem_reg  <= rem_next;
                kind_reg <= kind_next;
                seq_reg  <= seq_next;
                code_reg <= code_next;
                opc_reg  <= opc_next;
                val_reg  <= val_next;
                size_reg <= size_next;
                len_reg  <= len_next;
            end
            if (in_ready)
                s1_v_reg <= accept && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
            s1_rec_reg <= rec;
    end

endmodule

`default_nettype wire

@@ rtl/core/xpid_slot.sv @@
// Context slot pipeline: sequence modulo slot count by reciprocal multiply,
// back multiply and one correction, ending in the output register.
// Depends on xpid_pkg.
`default_nettype none

module xpid_slot #(
    parameter int unsigned CONTEXT_SLOTS = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sum_valid,
    output logic                sum_ready,
    input  xpid_pkg::xpid_sum_t sum,
    output logic                out_valid,
    input  logic                out_ready,
    output xpid_pkg::xpid_sum_t out_rec,
    output logic [7:0]          out_slot
);
    import xpid_pkg::*;

    localparam int unsigned RW = $clog2(CONTEXT_SLOTS) + 1;
    localparam logic [31:0]  RECIP  = 32'((64'd1 << 32) / CONTEXT_SLOTS);
    localparam logic [31:0]  SLOTS  = 32'(CONTEXT_SLOTS);
    localparam logic [RW-1:0] SLOTS_R = RW'(CONTEXT_SLOTS);

    logic        p1_v_reg;
    logic        p2_v_reg;
    logic        o_v_reg;
    xpid_sum_t   p1_rec_reg;
    xpid_sum_t   p2_rec_reg;
    xpid_sum_t   o_rec_reg;
    logic [31:0] p1_q_reg;
    logic [31:0] p2_qc_reg;
    logic [7:0]  o_slot_reg;
    logic        o_rdy;
    logic        p2_rdy;
    logic        p1_rdy;
    logic [63:0] prod_q;
    logic [63:0] prod_qc;
    logic [31:0] diff;
    logic [RW-1:0] rem;
    logic [RW-1:0] rem_fix;
    logic [31:0] rem_ext;

    assign o_rdy     = !o_v_reg || out_ready;
    assign p2_rdy    = !p2_v_reg || o_rdy;
    assign p1_rdy    = !p1_v_reg || p2_rdy;
    assign sum_ready = p1_rdy;

    // quotient estimate is exact or one low
    assign prod_q  = {32'd0, sum.seq} * {32'd0, RECIP};
    assign prod_qc = {32'd0, p1_q_reg} * {32'd0, SLOTS};
    assign diff    = p2_rec_reg.seq - p2_qc_reg;
    assign rem     = diff[RW-1:0];
    assign rem_fix = (rem >= SLOTS_R) ? rem - SLOTS_R : rem;
    assign rem_ext = 32'(rem_fix);

    assign out_valid = o_v_reg;
    assign out_rec   = o_rec_reg;
    assign out_slot  = o_slot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
            o_v_reg  <= 1'b0;
        end
        else
        begin
            if (p1_rdy)
                p1_v_reg <= sum_valid;
            if (p2_rdy)
                p2_v_reg <= p1_v_reg;
            if (o_rdy)
                o_v_reg <= p2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p1_rdy && sum_valid)
        begin
            p1_rec_reg <= sum;
            p1_q_reg   <= prod_q[63:32];
        end
        if (p2_rdy && p1_v_reg)
        begin
            p2_rec_reg <= p1_rec_reg;
            p2_qc_reg  <= prod_qc[31:0];
        end
        if (o_rdy && p2_v_reg)
        begin
            o_rec_reg  <= p2_rec_reg;
            o_slot_reg <= rem_ext[7:0];
        end
    end

endmodule

`default_nettype wire
